// ===== hw/rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the serial frame receiver
// Command, event and register codes, receive modes and the result record
// passed from the control stage to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  // Command codes of an input item
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_SENT    = 2'd2;

  // Event codes of a result item
  localparam logic [1:0] EV_PAYLOAD  = 2'd0;
  localparam logic [1:0] EV_FRAME    = 2'd1;
  localparam logic [1:0] EV_ACK      = 2'd2;
  localparam logic [1:0] EV_FLUSH    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [1:0] REG_CRC_POLY    = 2'd1;

  // Register reset values
  localparam logic [6:0]  MAX_PAYLOAD_RST = 7'd125;
  localparam logic [15:0] CRC_POLY_RST    = 16'hA001;

  // Link constants
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [6:0]  ACK_BASE  = 7'h7E;
  localparam logic [7:0]  ACK_BAD   = 8'h7E;
  localparam logic [7:0]  ACK_GOOD  = 8'hFF;
  localparam logic [6:0]  CRC_BYTES = 7'd2;

  // Receive modes
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RX    = 2'd1,
    MODE_FLUSH = 2'd2
  } rx_mode_t;

  // One result item
  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;
    logic [6:0] frame_length;
    logic       crc_ok;
    logic [7:0] ack_to_send;
    logic       ack_success;
  } sfr_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfr_crc.sv =====
// ----------------------------------------------------------------------------
// sfr_crc: byte-wide reflected CRC16 update
// Folds one byte into the running remainder, eight bit steps, LSB first,
// with a programmable polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_crc (
  input  wire  logic [15:0] crc,
  input  wire  logic [7:0]  data,
  input  wire  logic [15:0] poly,
  output logic [15:0]       crc_next
);

  logic [15:0] acc;

  // Shift out eight bits, folding in the polynomial on a set LSB
  always_comb begin
    acc = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ poly;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_next = acc;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfr_ctrl: input register, receive state and frame decode
// Holds the accepted item, decodes headers, payload and CRC bytes, keeps
// the link state and the configuration registers, and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ctrl (
  input  wire  logic                 clk,
  input  wire  logic                 rst,
  input  wire  logic                 in_valid,
  output logic                       in_stall,
  input  wire  logic [1:0]           cmd,
  input  wire  logic [7:0]           rx_byte,
  input  wire  logic                 wr_en,
  input  wire  logic [1:0]           wr_index,
  input  wire  logic [15:0]          wr_data,
  input  wire  logic                 out_free,
  output logic                       res_valid,
  output sfr_pkg::sfr_result_t       res
);

  // Input register
  logic       in_vld;
  logic [1:0] in_cmd;
  logic [7:0] in_byte;

  // Configuration
  logic [6:0]  max_payload;
  logic [15:0] crc_polynomial;

  // Link state
  sfr_pkg::rx_mode_t rx_mode, rx_mode_next;
  logic [6:0]  bytes_remaining, bytes_remaining_next;
  logic [6:0]  payload_total, payload_total_next;
  logic [15:0] running_crc, running_crc_next;
  logic        awaiting_ack, awaiting_ack_next;

  logic        step;
  logic [15:0] crc_upd;
  logic [6:0]  hdr_len;
  logic [7:0]  len_limit;
  logic [6:0]  rem_dec;

  assign step     = in_vld && out_free;
  assign in_stall = in_vld && !out_free;

  // Load the input register whenever it is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_stall) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_cmd  <= cmd;
      in_byte <= rx_byte;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= sfr_pkg::MAX_PAYLOAD_RST;
      crc_polynomial <= sfr_pkg::CRC_POLY_RST;
    end else if (wr_en) begin
      if (wr_index == sfr_pkg::REG_MAX_PAYLOAD) begin
        max_payload <= wr_data[6:0];
      end else if (wr_index == sfr_pkg::REG_CRC_POLY) begin
        crc_polynomial <= wr_data;
      end
    end
  end

  sfr_crc u_crc (
    .crc      (running_crc),
    .data     (in_byte),
    .poly     (crc_polynomial),
    .crc_next (crc_upd)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode         <= sfr_pkg::MODE_IDLE;
      bytes_remaining <= 7'd0;
      payload_total   <= 7'd0;
      running_crc     <= sfr_pkg::CRC_INIT;
      awaiting_ack    <= 1'b0;
    end else if (step) begin
      rx_mode         <= rx_mode_next;
      bytes_remaining <= bytes_remaining_next;
      payload_total   <= payload_total_next;
      running_crc     <= running_crc_next;
      awaiting_ack    <= awaiting_ack_next;
    end
  end

  assign hdr_len   = in_byte[6:0];
  assign len_limit = {1'b0, max_payload} + {1'b0, sfr_pkg::CRC_BYTES};
  assign rem_dec   = bytes_remaining - 7'd1;

  // Decode one item: next state and result
  always_comb begin
    rx_mode_next         = rx_mode;
    bytes_remaining_next = bytes_remaining;
    payload_total_next   = payload_total;
    running_crc_next     = running_crc;
    awaiting_ack_next    = awaiting_ack;
    res                  = '0;
    res_valid            = 1'b0;

    case (in_cmd)
      sfr_pkg::CMD_TIMEOUT: begin
        rx_mode_next         = sfr_pkg::MODE_IDLE;
        bytes_remaining_next = 7'd0;
        awaiting_ack_next    = 1'b0;
      end
      sfr_pkg::CMD_SENT: begin
        awaiting_ack_next = 1'b1;
      end
      sfr_pkg::CMD_BYTE: begin
        if (rx_mode == sfr_pkg::MODE_FLUSH) begin
          // drop bytes until a timeout
        end else if (rx_mode == sfr_pkg::MODE_RX && bytes_remaining != 7'd0) begin
          running_crc_next     = crc_upd;
          bytes_remaining_next = rem_dec;
          if (bytes_remaining > sfr_pkg::CRC_BYTES) begin
            res_valid        = 1'b1;
            res.event_res    = sfr_pkg::EV_PAYLOAD;
            res.payload_byte = in_byte;
            res.byte_index   = payload_total - (bytes_remaining - sfr_pkg::CRC_BYTES);
          end else if (rem_dec == 7'd0) begin
            rx_mode_next     = sfr_pkg::MODE_IDLE;
            res_valid        = 1'b1;
            res.event_res    = sfr_pkg::EV_FRAME;
            res.frame_length = payload_total;
            res.crc_ok       = (crc_upd == 16'h0000);
            res.ack_to_send  = (crc_upd == 16'h0000) ? sfr_pkg::ACK_GOOD : sfr_pkg::ACK_BAD;
          end
        end else begin
          // Header byte
          rx_mode_next         = sfr_pkg::MODE_IDLE;
          bytes_remaining_next = 7'd0;
          res_valid            = 1'b1;
          if (^in_byte) begin
            rx_mode_next  = sfr_pkg::MODE_FLUSH;
            res.event_res = sfr_pkg::EV_FLUSH;
          end else if (awaiting_ack && hdr_len >= sfr_pkg::ACK_BASE) begin
            awaiting_ack_next = 1'b0;
            res.event_res     = sfr_pkg::EV_ACK;
            res.ack_success   = hdr_len[0];
          end else if (hdr_len > sfr_pkg::CRC_BYTES && {1'b0, hdr_len} <= len_limit) begin
            rx_mode_next         = sfr_pkg::MODE_RX;
            bytes_remaining_next = hdr_len;
            payload_total_next   = hdr_len - sfr_pkg::CRC_BYTES;
            running_crc_next     = sfr_pkg::CRC_INIT;
            res_valid            = 1'b0;
          end else begin
            rx_mode_next  = sfr_pkg::MODE_FLUSH;
            res.event_res = sfr_pkg::EV_FLUSH;
          end
        end
      end
      default: begin
        // unused command: no effect
      end
    endcase

    res_valid = res_valid && step;
  end

  // A frame in progress always has bytes left to take
  a_rx_has_bytes: assert property (@(posedge clk) disable iff (rst)
    rx_mode == sfr_pkg::MODE_RX |-> bytes_remaining != 7'd0)
    else $error("receiving with no bytes remaining");

  // Bytes left never exceed payload plus the two CRC bytes
  a_rx_count: assert property (@(posedge clk) disable iff (rst)
    rx_mode == sfr_pkg::MODE_RX |->
      ({1'b0, payload_total} + 8'd2) >= {1'b0, bytes_remaining})
    else $error("byte count beyond frame length");

  // A timeout returns to idle and drops the ack wait
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    step && in_cmd == sfr_pkg::CMD_TIMEOUT |=>
      rx_mode == sfr_pkg::MODE_IDLE && !awaiting_ack)
    else $error("timeout did not resync");

  // Payload items come only from a frame in progress
  a_payload_src: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == sfr_pkg::EV_PAYLOAD |-> rx_mode == sfr_pkg::MODE_RX)
    else $error("payload item outside a frame");

endmodule

`default_nettype wire

// ===== hw/rtl/sfr_out_reg.sv =====
// ----------------------------------------------------------------------------
// sfr_out_reg: result register
// Holds one result item until the receiver takes it and tells the control
// stage when it may hand over the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_out_reg (
  input  wire  logic                 clk,
  input  wire  logic                 rst,
  input  wire  logic                 res_valid,
  input  wire  sfr_pkg::sfr_result_t res,
  output logic                       out_free,
  output logic                       out_valid,
  input  wire  logic                 out_stall,
  output sfr_pkg::sfr_result_t       out_data
);

  assign out_free = !out_valid || !out_stall;

  // Advance the valid flag when the slot is free or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  // Capture the payload of a new result item
  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/serial_frame_receiver_ack.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver_ack: length-prefixed UART frame receiver with ack
// Decodes header, payload and CRC16 bytes, reports payload bytes, frame
// completion with the ack byte to send, received acks and line errors.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   cmd, rx_byte
//   out      source     out_valid/out_stall event_res .. ack_success
//   config   sink       wr_en               wr_index, wr_data
//
// An item passes from acceptance through the input register and then the
// result register; one item is accepted every cycle while in_stall is low.
// The byte-wide CRC update sits between the two registers.
// Reset is synchronous; it restores the register defaults and idle mode.
// A stalled result register stalls the input only once the input register
// is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_ack (
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  logic [1:0]  cmd,
  input  wire  logic [7:0]  rx_byte,
  input  wire  logic        wr_en,
  input  wire  logic [1:0]  wr_index,
  input  wire  logic [15:0] wr_data,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output logic [1:0]        event_res,
  output logic [7:0]        payload_byte,
  output logic [6:0]        byte_index,
  output logic [6:0]        frame_length,
  output logic              crc_ok,
  output logic [7:0]        ack_to_send,
  output logic              ack_success
);

  logic                 out_free;
  logic                 res_valid;
  sfr_pkg::sfr_result_t res;
  sfr_pkg::sfr_result_t out_data;

  sfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  sfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Split the result record onto its ports
  assign event_res    = out_data.event_res;
  assign payload_byte = out_data.payload_byte;
  assign byte_index   = out_data.byte_index;
  assign frame_length = out_data.frame_length;
  assign crc_ok       = out_data.crc_ok;
  assign ack_to_send  = out_data.ack_to_send;
  assign ack_success  = out_data.ack_success;

endmodule

`default_nettype wire
